### design/pfb_pkg.sv
// Shared constants, types and stamp offset tables for the page framebuffer.
package pfb_pkg;

    localparam int FRAME_WIDTH  = 84;
    localparam int FRAME_HEIGHT = 48;
    localparam int FRAME_PAGES  = (FRAME_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES  = FRAME_WIDTH * FRAME_PAGES;
    localparam int ADDR_W       = $clog2(FRAME_BYTES);

    typedef logic [1:0]        t_action;
    typedef logic [7:0]        t_coord;
    typedef logic [7:0]        t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_action ACT_PIXEL = 2'd0;
    localparam t_action ACT_DOT   = 2'd1;
    localparam t_action ACT_CROSS = 2'd2;
    localparam t_action ACT_READ  = 2'd3;

    // Column offset of pixel k of a stamp.
    function automatic t_coord stamp_dx(t_action act, logic [1:0] k);
        t_coord d;
        d = 8'd0;
        case (act)
            ACT_DOT:   d = {7'd0, k[0]};
            ACT_CROSS: begin
                case (k)
                    2'd0:    d = 8'd0;
                    2'd1:    d = 8'd2;
                    default: d = 8'd1;
                endcase
            end
            default:   d = 8'd0;
        endcase
        return d;
    endfunction

    // Row offset of pixel k of a stamp; 8'hFF stands for minus one.
    function automatic t_coord stamp_dy(t_action act, logic [1:0] k);
        t_coord d;
        d = 8'd0;
        case (act)
            ACT_DOT:   d = {7'd0, k[1]};
            ACT_CROSS: begin
                case (k)
                    2'd2:    d = 8'd1;
                    2'd3:    d = 8'hFF;
                    default: d = 8'd0;
                endcase
            end
            default:   d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

### design/pfb_if.sv
// Valid/ready channel interfaces for the framebuffer requests and read data.
interface pfb_req_if;
    logic             valid;
    logic             ready;
    pfb_pkg::t_action action;
    pfb_pkg::t_coord  x;
    pfb_pkg::t_coord  y;

    modport source (output valid, output action, output x, output y, input ready);
    modport sink   (input valid, input action, input x, input y, output ready);
endinterface

interface pfb_rsp_if;
    logic           valid;
    logic           ready;
    pfb_pkg::t_byte pixel_byte;
    logic           last;

    modport source (output valid, output pixel_byte, output last, input ready);
    modport sink   (input valid, input pixel_byte, input last, output ready);
endinterface

### design/page_framebuffer_plot.sv
// Page framebuffer top level: sequencer, shared address unit and byte store.
// Each pixel is a read-modify-write of the single-port store: a read state, then a write.
// Plot pixel does this once, dot and cross once for each of their four pixels;
// read-next reads one byte, clears it, and may wait for the output register.
// After reset a clearing pass zeroes all 504 bytes of the store with ready low.
// Read data leaves through an output register, so requests flow while it waits.
module page_framebuffer_plot (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfb_req_if.sink   i_req,
    pfb_rsp_if.source o_rsp
);
    import pfb_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_WR    = 2'd3;

    logic [1:0] r_state, n_state;
    t_addr      r_clr_cnt, n_clr_cnt;
    t_addr      r_rdptr, n_rdptr;
    t_action    r_act, n_act;
    t_coord     r_x, n_x;
    t_coord     r_y, n_y;
    logic [1:0] r_k, n_k;
    t_addr      r_addr, n_addr;
    logic       r_hit, n_hit;
    logic [2:0] r_bit, n_bit;
    logic       r_out_valid, n_out_valid;
    t_byte      r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    t_byte      r_mem [FRAME_BYTES];
    t_byte      r_rdata;
    logic       w_we;
    t_addr      w_mem_addr;
    t_byte      w_wdata;

    t_coord     w_px, w_py;
    logic       w_in_range;
    t_addr      w_calc_addr;
    logic       w_out_free;
    logic       w_last_pix;

    // Shared address unit: one offset add per pixel, then page times width plus column.
    assign w_px        = r_x + stamp_dx(r_act, r_k);
    assign w_py        = r_y + stamp_dy(r_act, r_k);
    assign w_in_range  = ({1'b0, w_px} < 9'(FRAME_WIDTH)) && ({1'b0, w_py} < 9'(FRAME_HEIGHT));
    assign w_calc_addr = ADDR_W'(w_py[7:3]) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(w_px);

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_last_pix  = (r_act == ACT_PIXEL) || (r_k == 2'd3);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_mem_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_mem_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_rdptr     = r_rdptr;
        n_act       = r_act;
        n_x         = r_x;
        n_y         = r_y;
        n_k         = r_k;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_mem_addr  = r_addr;
        w_wdata     = r_rdata | t_byte'(8'd1 << r_bit);

        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_mem_addr = r_clr_cnt;
                w_wdata    = '0;
                n_clr_cnt  = r_clr_cnt + 1'b1;
                if (r_clr_cnt == t_addr'(FRAME_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_x     = i_req.x;
                    n_y     = i_req.y;
                    n_k     = 2'd0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_act == ACT_READ) begin
                    w_mem_addr = r_rdptr;
                    n_addr     = r_rdptr;
                    n_hit      = 1'b1;
                end else begin
                    w_mem_addr = w_calc_addr;
                    n_addr     = w_calc_addr;
                    n_hit      = w_in_range;
                    n_bit      = w_py[2:0];
                end
                n_state = ST_WR;
            end
            ST_WR: begin
                if (r_act == ACT_READ) begin
                    // Hold the byte until the output register can take it.
                    if (w_out_free) begin
                        w_we        = 1'b1;
                        w_wdata     = '0;
                        n_out_valid = 1'b1;
                        n_out_byte  = r_rdata;
                        n_out_last  = (r_rdptr == t_addr'(FRAME_BYTES - 1));
                        n_rdptr     = n_out_last ? '0 : r_rdptr + 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    w_we = r_hit;
                    if (w_last_pix) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_rdptr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_rdptr     <= n_rdptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_x        <= n_x;
        r_y        <= n_y;
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_hit      <= n_hit;
        r_bit      <= n_bit;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pixel_byte = r_out_byte;
    assign o_rsp.last       = r_out_last;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("request accepted during the clearing pass");

    a_rdptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdptr <= t_addr'(FRAME_BYTES - 1))
        else $error("read pointer beyond the frame");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("new request taken while one is in progress");

    a_rsp_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_act == ACT_READ && r_state == ST_WR))
        else $error("read data produced by a plot request");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && o_rsp.last) |-> (r_rdptr == '0))
        else $error("read pointer did not wrap after the final byte");

endmodule
